// ===== rtl/stbt_pkg.sv =====
// Shared types, widths, codes and helpers for the supertrend band tracker.
// No dependencies; imported by supertrend_band_tracker.
package stbt_pkg;

    localparam int PRICE_W            = 32;
    localparam int BAND_W             = 42;
    localparam int TREND_W            = 2;
    localparam int PERIOD_CFG_W       = 7;
    localparam int FACTOR_W           = 16;
    localparam int PROD_W             = FACTOR_W + PRICE_W;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 16;
    localparam int IN_DATA_W          = 3 * PRICE_W;
    localparam int OUT_FIELDS_W       = TREND_W + 2 * BAND_W + PRICE_W;
    localparam int OUT_DATA_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int MAX_PERIOD_DEFAULT = 64;

    localparam logic [PERIOD_CFG_W-1:0] ATR_PERIOD_RESET  = 7'd10;
    localparam logic [FACTOR_W-1:0]     BAND_FACTOR_RESET = 16'd768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATR_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_FACTOR = 1'd1;

    // Trend codes.
    localparam logic signed [TREND_W-1:0] TREND_NONE = 2'sb00;
    localparam logic signed [TREND_W-1:0] TREND_UP   = 2'sb01;
    localparam logic signed [TREND_W-1:0] TREND_DOWN = 2'sb11;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_TR,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_BAND,
        ST_RATCHET,
        ST_FINISH
    } stbt_state_t;

    function automatic logic [PRICE_W-1:0] abs_diff(input logic [PRICE_W-1:0] a,
                                                     input logic [PRICE_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/stbt_divider.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Standalone; used by supertrend_band_tracker for the average true range.
module stbt_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    // Bring down the next dividend bit and try the subtraction.
    assign rem_shift = {rem_reg, quot_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(rem_shift - {1'b0, divisor}) : DEN_W'(rem_shift);
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor))
        else $error("partial remainder not below divisor");

endmodule

// ===== rtl/supertrend_band_tracker.sv =====
// Supertrend band tracker: true range, windowed average true range, ratcheted bands.
// Steps per item: true range, window sum, then, once the window is full, divider start, the
// bit-serial ATR divide, multiply, band and ratchet; the finish step loads the output register.
// A new item is taken in the idle step after the result loads, and the output register lets it
// start while a result waits; finish holds while that register is full and not taken.
// Reset (rst_n low, asynchronous) clears control, sum, counters, bands.
module supertrend_band_tracker #(
    parameter int MAX_PERIOD = stbt_pkg::MAX_PERIOD_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: high_price[31:0], low_price[63:32], close_price[95:64].
    input  logic [stbt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result items.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0 up: trend_direction[1:0], upper_band_support[43:2],
    // lower_band_resist[85:44], avg_true_range[117:86], zero padding [119:118].
    output logic [stbt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0 up: result_valid[0].
    output logic                             m_axis_tuser,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import stbt_pkg::*;

    // Widths that follow from the deepest window.
    localparam int PTR_W  = $clog2(MAX_PERIOD);
    localparam int PER_W  = $clog2(MAX_PERIOD + 1);
    localparam int SEEN_W = $clog2(MAX_PERIOD + 2);
    localparam int SUM_W  = PRICE_W + PTR_W;
    localparam int EXT_W  = BAND_W + 1;
    localparam int WIDE_W = 51;

    localparam int TREND_LSB = 0;
    localparam int UP_LSB    = TREND_LSB + TREND_W;
    localparam int DOWN_LSB  = UP_LSB + BAND_W;
    localparam int ATR_LSB   = DOWN_LSB + BAND_W;
    localparam int PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    stbt_state_t state_reg;
    stbt_state_t state_next;

    // Configuration registers.
    logic [PERIOD_CFG_W-1:0] atr_period_reg;
    logic [FACTOR_W-1:0]     band_factor_reg;

    // Window bookkeeping.
    logic [SUM_W-1:0]   sum_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [SEEN_W-1:0]  seen_reg;
    logic [PRICE_W-1:0] last_close_reg;

    // Per-item working registers.
    logic [PRICE_W-1:0] high_reg;
    logic [PRICE_W-1:0] low_reg;
    logic [PRICE_W-1:0] close_reg;
    logic [PRICE_W-1:0] prev_close_reg;
    logic [PRICE_W-1:0] tr_reg;
    logic [PRICE_W-1:0] atr_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               valid_reg;
    logic signed [BAND_W-1:0] up_reg;
    logic signed [BAND_W-1:0] down_reg;

    // Held indicator state.
    logic signed [TREND_W-1:0] prior_trend_reg;
    logic signed [BAND_W-1:0]  prior_up_reg;
    logic signed [BAND_W-1:0]  prior_down_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_user_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Window memory and its registered read port.
    logic [PRICE_W-1:0] window_mem [MAX_PERIOD];
    logic [PRICE_W-1:0] win_rd_reg;
    logic               win_we;

    // Control decoded by the sequencer.
    logic in_ready;
    logic cfg_take;
    logic in_take;
    logic div_start;
    logic out_load;

    logic [PER_W-1:0]   period_eff;
    logic [SEEN_W-1:0]  period_plus1;
    logic               window_full;
    logic [PER_W-1:0]   ptr_plus;
    logic [PTR_W-1:0]   ptr_wrap;
    logic [PRICE_W-1:0] hl_range;
    logic [PRICE_W-1:0] gap_high;
    logic [PRICE_W-1:0] gap_low;
    logic [PRICE_W-1:0] tr_max;

    logic [PRICE_W:0]          mid2;
    logic signed [WIDE_W-1:0]  mid24;
    logic signed [WIDE_W-1:0]  fa_wide;
    logic signed [WIDE_W-1:0]  up_wide;
    logic signed [WIDE_W-1:0]  down_wide;

    logic signed [EXT_W-1:0] prev_close_s;
    logic signed [EXT_W-1:0] close_s;
    logic signed [EXT_W-1:0] prior_up_s;
    logic signed [EXT_W-1:0] prior_down_s;
    logic signed [EXT_W-1:0] up_s;
    logic signed [EXT_W-1:0] down_s;

    logic               div_done;
    logic [SUM_W-1:0]   div_quot;

    // The period written is clamped to 1..MAX_PERIOD; zero behaves as one.
    always_comb
    begin
        if (atr_period_reg == '0)
        begin
            period_eff = PER_W'(1);
        end
        else if (int'(atr_period_reg) > MAX_PERIOD)
        begin
            period_eff = PER_W'(MAX_PERIOD);
        end
        else
        begin
            period_eff = PER_W'(atr_period_reg);
        end
    end

    assign period_plus1 = SEEN_W'(period_eff) + SEEN_W'(1);
    assign window_full  = (seen_reg == period_plus1);
    assign ptr_plus     = PER_W'(ptr_reg) + PER_W'(1);
    assign ptr_wrap     = (ptr_plus >= period_eff) ? '0 : ptr_plus[PTR_W-1:0];

    // True range: the widest of the candle span and the gaps from the previous close.
    // A low above the high contributes nothing from the span term.
    assign hl_range = (high_reg >= low_reg) ? (high_reg - low_reg) : '0;
    assign gap_high = abs_diff(high_reg, prev_close_reg);
    assign gap_low  = abs_diff(low_reg, prev_close_reg);

    always_comb
    begin
        tr_max = hl_range;
        if (gap_high > tr_max)
        begin
            tr_max = gap_high;
        end
        if (gap_low > tr_max)
        begin
            tr_max = gap_low;
        end
    end

    // Bands are formed at 24 fraction bits, then floored to 16 by an arithmetic shift.
    // The midpoint is below 2^40 and factor times ATR below 2^48, so the shifted value
    // always lands inside the 42-bit signed range and no saturation is needed.
    assign mid2      = {1'b0, high_reg} + {1'b0, low_reg};
    assign mid24     = $signed({{(WIDE_W - PRICE_W - 8){1'b0}}, mid2, 7'b0});
    assign fa_wide   = $signed({{(WIDE_W - PROD_W){1'b0}}, prod_reg});
    assign up_wide   = mid24 - fa_wide;
    assign down_wide = mid24 + fa_wide;

    // Comparisons for the ratchet and the trend run one bit wider than the bands so
    // the unsigned prices compare correctly against signed bands.
    assign prev_close_s = $signed({{(EXT_W - PRICE_W){1'b0}}, prev_close_reg});
    assign close_s      = $signed({{(EXT_W - PRICE_W){1'b0}}, close_reg});
    assign prior_up_s   = EXT_W'(prior_up_reg);
    assign prior_down_s = EXT_W'(prior_down_reg);
    assign up_s         = EXT_W'(up_reg);
    assign down_s       = EXT_W'(down_reg);

    // Sequencer: next state and handshake controls.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        win_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (s_axis_tvalid && !cfg_valid)
                begin
                    state_next = ST_TR;
                end
            end
            ST_TR:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                win_we = (seen_reg != '0);
                // The window is full after this item once at least P candles came before.
                if (SEEN_W'(period_eff) <= seen_reg)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_BAND;
            end
            ST_BAND:
            begin
                state_next = ST_RATCHET;
            end
            ST_RATCHET:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_take = cfg_valid && cfg_ready;
    assign in_take  = s_axis_tvalid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration, window counters and held indicator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atr_period_reg  <= ATR_PERIOD_RESET;
            band_factor_reg <= BAND_FACTOR_RESET;
            sum_reg         <= '0;
            ptr_reg         <= '0;
            seen_reg        <= '0;
            last_close_reg  <= '0;
            prior_trend_reg <= TREND_NONE;
            prior_up_reg    <= '0;
            prior_down_reg  <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                case (cfg_index)
                    CFG_ATR_PERIOD:
                    begin
                        // A new period restarts the averaging; bands and trend stay.
                        atr_period_reg <= cfg_data[PERIOD_CFG_W-1:0];
                        sum_reg        <= '0;
                        ptr_reg        <= '0;
                        seen_reg       <= '0;
                    end
                    CFG_BAND_FACTOR:
                    begin
                        band_factor_reg <= cfg_data[FACTOR_W-1:0];
                    end
                    default:
                    begin
                        band_factor_reg <= band_factor_reg;
                    end
                endcase
            end

            if (in_take)
            begin
                last_close_reg <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
            end

            // Drop the oldest range as soon as its read data is in.
            if (state_reg == ST_TR && window_full)
            begin
                sum_reg <= sum_reg - SUM_W'(win_rd_reg);
            end

            if (state_reg == ST_SUM)
            begin
                if (seen_reg != '0)
                begin
                    sum_reg <= sum_reg + SUM_W'(tr_reg);
                    ptr_reg <= ptr_wrap;
                end
                if (!window_full)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
                valid_reg <= (SEEN_W'(period_eff) <= seen_reg);
            end

            if (state_reg == ST_RATCHET)
            begin
                // Up band holds its higher prior value while the last close stayed above
                // it; the down band mirrors that below.
                if (prev_close_s > prior_up_s && prior_up_s > up_s)
                begin
                    prior_up_reg <= prior_up_reg;
                end
                else
                begin
                    prior_up_reg <= up_reg;
                end
                if (prev_close_s < prior_down_s && prior_down_s < down_s)
                begin
                    prior_down_reg <= prior_down_reg;
                end
                else
                begin
                    prior_down_reg <= down_reg;
                end
                if (close_s > prior_down_s)
                begin
                    prior_trend_reg <= TREND_UP;
                end
                else if (close_s < prior_up_s)
                begin
                    prior_trend_reg <= TREND_DOWN;
                end
            end
        end
    end

    // Per-item working data; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            high_reg       <= s_axis_tdata[PRICE_W-1:0];
            low_reg        <= s_axis_tdata[2*PRICE_W-1:PRICE_W];
            close_reg      <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
            prev_close_reg <= last_close_reg;
        end
        if (state_reg == ST_TR)
        begin
            tr_reg <= tr_max;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            atr_reg <= div_quot[PRICE_W-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(band_factor_reg) * PROD_W'(atr_reg);
        end
        if (state_reg == ST_BAND)
        begin
            up_reg   <= up_wide[49:8];
            down_reg <= down_wide[49:8];
        end
    end

    // Window memory: the read port follows the pointer every cycle, so the oldest
    // range is already waiting when an item arrives.
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            window_mem[ptr_reg] <= tr_reg;
        end
        win_rd_reg <= window_mem[ptr_reg];
    end

    // Serial divider forms the ATR as the floor of sum over period.
    stbt_divider #(
        .NUM_W (SUM_W),
        .DEN_W (PER_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (period_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Output register. Before the window fills, the held bands and trend are
    // repeated and the ATR reads zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_user_reg <= valid_reg;
            out_data_reg <= {{PAD_W{1'b0}},
                             (valid_reg ? atr_reg : {PRICE_W{1'b0}}),
                             prior_down_reg,
                             prior_up_reg,
                             prior_trend_reg};
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_TR))
        else $error("accepted item did not start the sequence");

    a_ptr_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        PER_W'(ptr_reg) < period_eff)
        else $error("window pointer beyond period");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= period_plus1)
        else $error("candle count beyond period plus one");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_invalid_zero_atr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_user_reg) |-> (out_data_reg[ATR_LSB +: PRICE_W] == '0))
        else $error("nonzero ATR on a not-valid result");

endmodule
